@@ rtl/core/csem_pkg.sv @@
// Shared types, constants and helper functions for the counting semaphore table.
`timescale 1ns / 1ps
`default_nettype none
package csem_pkg;

    localparam int NUM_SEMS        = 32;
    localparam int WAITERS_PER_SEM = 16;
    localparam int PID_BITS        = 6;
    localparam int COUNT_BITS      = 16;

    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int INIT_W   = 16;
    localparam int HANDLE_W = $clog2(NUM_SEMS);
    localparam int USED_W   = $clog2(NUM_SEMS + 1);
    localparam int QPTR_W   = $clog2(WAITERS_PER_SEM);
    localparam int QFILL_W  = $clog2(WAITERS_PER_SEM + 1);
    localparam int WDEPTH   = NUM_SEMS * WAITERS_PER_SEM;
    localparam int ADDR_W   = $clog2(WDEPTH);
    localparam int EXT_W    = ((COUNT_BITS > INIT_W) ? COUNT_BITS : INIT_W) + 1;

    localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_WAIT   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SIGNAL = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef logic signed [COUNT_BITS-1:0] t_count;

    localparam logic signed [EXT_W-1:0] CNT_MAX_EXT =
        EXT_W'((64'sd1 <<< (COUNT_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_W-1:0] CNT_MIN_EXT =
        EXT_W'(-(64'sd1 <<< (COUNT_BITS - 1)));
    localparam t_count CNT_MAX  = COUNT_BITS'(CNT_MAX_EXT);
    localparam t_count CNT_MIN  = COUNT_BITS'(CNT_MIN_EXT);
    localparam t_count CNT_ZERO = COUNT_BITS'(0);
    localparam t_count CNT_ONE  = COUNT_BITS'(1);
    localparam logic [QFILL_W-1:0] QFILL_MAX = QFILL_W'(WAITERS_PER_SEM);
    localparam logic [QPTR_W-1:0]  QPTR_LAST = QPTR_W'(WAITERS_PER_SEM - 1);

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [HANDLE_W-1:0]      handle;
        logic [PID_BITS-1:0]      caller_pid;
        logic signed [INIT_W-1:0] initial_count;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HANDLE_W-1:0] new_handle;
        logic                caller_blocks;
        logic                wake_valid;
        logic [PID_BITS-1:0] wake_pid;
    } t_out;

    typedef struct packed {
        logic                we;
        logic                re;
        logic [ADDR_W-1:0]   addr;
        logic [PID_BITS-1:0] wdata;
    } t_mem_req;

    function automatic t_count clamp_init(input logic signed [INIT_W-1:0] v);
        logic signed [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        if (ext > CNT_MAX_EXT) begin
            return CNT_MAX;
        end else if (ext < CNT_MIN_EXT) begin
            return CNT_MIN;
        end
        return COUNT_BITS'(ext);
    endfunction

    function automatic logic [QPTR_W-1:0] q_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_LAST) ? '0 : p + 1'b1;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/counting_semaphore_table_top.sv @@
// Top level of the counting semaphore table: request register, decision, result register.
// Usage:
//   Requests enter on i_in_valid / o_in_stall / i_in_data; a transfer takes place at a
//   rising edge with valid high and stall low. Each request gives exactly one result on
//   o_out_valid / i_out_stall / o_out_data, in request order.
//   A transferred request lands in the request register; its result is then registered
//   in the result register, from which o_out_data is driven. Throughput: one request per cycle
//   unless i_out_stall holds the result. The semaphore table is updated in the cycle
//   the request leaves the request register, and the waiter store is a single-port RAM
//   touched at most once per request (write on a blocking wait, read on a wake), so
//   back-to-back requests to the same semaphore see each other's effect.
//   Reset (i_rst_n low at a clock edge) empties both registers, frees all slots and
//   clears every queue pointer and fill count; counts and the waiter store are written
//   before they are ever read.
//   When the receiver stalls, the result holds in place; one further request may be
//   taken into the request register, after which o_in_stall rises until the result
//   is taken.
`timescale 1ns / 1ps
`default_nettype none
module counting_semaphore_table_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire csem_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output csem_pkg::t_out     o_out_data
);
    import csem_pkg::*;

    logic                r_req_valid;
    t_in                 r_req;
    logic                r_res_valid;
    t_out                r_res;
    logic                adv;
    logic                fire;
    t_out                ctrl_res;
    t_mem_req            mem_req;
    logic [PID_BITS-1:0] ram_rdata;

    assign adv        = !r_res_valid || !i_out_stall;
    assign fire       = r_req_valid && adv;
    assign o_in_stall = r_req_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req <= i_in_data;
        end
    end

    csem_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_req),
        .o_res   (ctrl_res),
        .o_mem   (mem_req)
    );

    csem_ram #(
        .WIDTH (PID_BITS),
        .DEPTH (WDEPTH)
    ) u_waiters (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_re    (mem_req.re),
        .i_addr  (mem_req.addr),
        .i_wdata (mem_req.wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (adv) begin
            r_res_valid <= r_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= ctrl_res;
        end
    end

    always_comb begin
        o_out_data          = r_res;
        o_out_data.wake_pid = r_res.wake_valid ? ram_rdata : '0;
    end

    assign o_out_valid = r_res_valid;

`ifndef NO_ASSERTIONS
    a_mem_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("waiter store written and read in one cycle");

    a_wake_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.re |=> (r_res_valid && r_res.wake_valid))
        else $error("waiter read without a wake result");

    a_wake_is_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.wake_valid) |->
            (o_out_data.status == ST_OK && !o_out_data.caller_blocks))
        else $error("wake reported with a bad status or a blocking caller");

    a_stall_holds_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_req_valid && !adv) |=> (r_req_valid && $stable(r_req)))
        else $error("pending request lost while the result stalls");
`endif

endmodule
`default_nettype wire

@@ rtl/core/csem_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/core/csem_ctrl.sv @@
// Semaphore state and per-request decision logic.
`timescale 1ns / 1ps
`default_nettype none
module csem_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_fire,
    input  wire csem_pkg::t_in      i_req,
    output csem_pkg::t_out          o_res,
    output csem_pkg::t_mem_req      o_mem
);
    import csem_pkg::*;

    logic [USED_W-1:0]  r_used_cnt;
    t_count             r_count [NUM_SEMS];
    logic [QPTR_W-1:0]  r_head  [NUM_SEMS];
    logic [QPTR_W-1:0]  r_tail  [NUM_SEMS];
    logic [QFILL_W-1:0] r_fill  [NUM_SEMS];

    logic                in_use;
    logic                slot_free;
    logic [HANDLE_W-1:0] free_idx;
    t_count              cur_cnt;
    t_count              sig_cnt;
    logic [QPTR_W-1:0]   cur_head;
    logic [QPTR_W-1:0]   cur_tail;
    logic [QFILL_W-1:0]  cur_fill;

    logic                do_create;
    logic                do_enq;
    logic                do_deq;
    logic                cnt_we;
    t_count              n_cnt;
    logic [HANDLE_W-1:0] cnt_idx;

    assign in_use    = (USED_W'(i_req.handle) < r_used_cnt);
    assign slot_free = (r_used_cnt < USED_W'(NUM_SEMS));
    assign free_idx  = HANDLE_W'(r_used_cnt);
    assign cur_cnt   = r_count[i_req.handle];
    assign cur_head  = r_head[i_req.handle];
    assign cur_tail  = r_tail[i_req.handle];
    assign cur_fill  = r_fill[i_req.handle];

    always_comb begin
        o_res     = '0;
        do_create = 1'b0;
        do_enq    = 1'b0;
        do_deq    = 1'b0;
        cnt_we    = 1'b0;
        n_cnt     = cur_cnt;
        cnt_idx   = i_req.handle;
        sig_cnt   = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + CNT_ONE;
        unique case (i_req.func)
            FN_CREATE: begin
                if (slot_free) begin
                    o_res.status     = ST_OK;
                    o_res.new_handle = free_idx;
                    do_create        = 1'b1;
                    cnt_we           = 1'b1;
                    cnt_idx          = free_idx;
                    n_cnt            = clamp_init(i_req.initial_count);
                end else begin
                    o_res.status = ST_FAIL;
                end
            end
            FN_WAIT: begin
                if (!in_use) begin
                    o_res.status = ST_FAIL;
                end else if (cur_cnt > CNT_ZERO) begin
                    cnt_we = 1'b1;
                    n_cnt  = cur_cnt - CNT_ONE;
                end else if (cur_fill >= QFILL_MAX) begin
                    o_res.status = ST_FULL;
                end else begin
                    do_enq              = 1'b1;
                    o_res.caller_blocks = 1'b1;
                end
            end
            FN_SIGNAL: begin
                if (!in_use) begin
                    o_res.status = ST_FAIL;
                end else begin
                    cnt_we = 1'b1;
                    n_cnt  = sig_cnt;
                    if ((sig_cnt > CNT_ZERO) && (cur_fill != '0)) begin
                        do_deq           = 1'b1;
                        o_res.wake_valid = 1'b1;
                        n_cnt            = sig_cnt - CNT_ONE;
                    end
                end
            end
            default: begin
                o_res.status = ST_FAIL;
            end
        endcase
    end

    always_comb begin
        o_mem.we    = i_fire && do_enq;
        o_mem.re    = i_fire && do_deq;
        o_mem.wdata = i_req.caller_pid;
        o_mem.addr  = ADDR_W'(i_req.handle) * ADDR_W'(WAITERS_PER_SEM)
                    + ADDR_W'(do_enq ? cur_tail : cur_head);
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && cnt_we) begin
            r_count[cnt_idx] <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_cnt <= '0;
            for (int i = 0; i < NUM_SEMS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_fire) begin
            if (do_create) begin
                r_used_cnt       <= r_used_cnt + 1'b1;
                r_head[free_idx] <= '0;
                r_tail[free_idx] <= '0;
                r_fill[free_idx] <= '0;
            end
            if (do_enq) begin
                r_tail[i_req.handle] <= q_next(cur_tail);
                r_fill[i_req.handle] <= cur_fill + 1'b1;
            end
            if (do_deq) begin
                r_head[i_req.handle] <= q_next(cur_head);
                r_fill[i_req.handle] <= cur_fill - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire
